[hw/rtl/gtfmtg_pkg.sv]
`default_nettype none
package gtfmtg_pkg;

    localparam int CELL_GRAN      = 8;
    localparam int MIN_VSYNCBP    = 11;
    localparam int MIN_VPORCH     = 1;
    localparam int C_PRIME        = 30;
    localparam int M_PRIME        = 300;
    localparam int HSYNC_PCT      = 8;
    localparam int VSYNCBP_SCALE  = 20000;
    localparam int PCLK_SCALE     = 10000;
    localparam int DUTY_OFF       = M_PRIME * 1000 / C_PRIME;
    localparam int PCLK_DIV       = PCLK_SCALE / CELL_GRAN;
    localparam int RRX_SCALE      = PCLK_SCALE * 1000;
    localparam int HB_DEN_MUL     = 2 * (300 / C_PRIME - 3);
    localparam int HB_DEN_ADD     = 2 * 3 * DUTY_OFF;
    // hsync cells = (htcells * 8) / 100 = (2 * htcells) / 25, by reciprocal
    localparam int HS_DIV         = 200 / HSYNC_PCT;
    localparam int HS_SHIFT       = 16;
    localparam int HS_RECIP       = ((1 << HS_SHIFT) + HS_DIV - 1) / HS_DIV;

    // pixel clock divide by reciprocal: idd split by PCLK_DIV, then remainder term
    localparam int     PCLK_R1_SHIFT = 38;
    localparam longint PCLK_R1       = ((longint'(1) << PCLK_R1_SHIFT)
                                        + longint'(PCLK_DIV) - 1) / longint'(PCLK_DIV);
    localparam int     PCLK_R2_SHIFT = 32;
    localparam longint PCLK_R2       = ((longint'(1) << PCLK_R2_SHIFT)
                                        + longint'(PCLK_DIV) - 1) / longint'(PCLK_DIV);

    localparam int DIV1_NW = 29;
    localparam int DIV1_DW = 15;
    localparam int DIV1_QW = 27;
    localparam int DIV2_NW = 39;
    localparam int DIV2_DW = 31;
    localparam int DIV2_QW = 8;
    localparam int DIV3_NW = 50;
    localparam int DIV3_DW = 30;
    localparam int DIV3_QW = 21;

    localparam logic [1:0] MODE_PROGRESSIVE = 2'd0;
    localparam logic [1:0] MODE_FIELD2_VBL  = 2'd1;
    localparam logic [1:0] MODE_NONE        = 2'd2;

    typedef struct packed {
        logic        err;
        logic        il;
        logic [12:0] h;
        logic [10:0] rr;
        logic [9:0]  xcells;
    } s1_t;

    typedef struct packed {
        logic        err;
        logic        il;
        logic [12:0] h;
        logic [9:0]  xcells;
        logic [15:0] vtot;
        logic [26:0] idd;
    } s2_t;

    typedef struct packed {
        logic        err;
        logic        il;
        logic [12:0] h;
        logic [9:0]  xcells;
        logic [15:0] vtot;
        logic [13:0] htot;
        logic [13:0] hsync;
        logic [13:0] hfp;
    } s3_t;

    typedef struct packed {
        s3_t         s3;
        logic [25:0] pclk;
    } s4_t;

endpackage
`default_nettype wire

[hw/rtl/gtfmtg_div.sv]
`default_nettype none
module gtfmtg_div #(
    parameter int NW = gtfmtg_pkg::DIV1_NW,
    parameter int DW = gtfmtg_pkg::DIV1_DW,
    parameter int QW = gtfmtg_pkg::DIV1_QW,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_vld,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    input  wire logic [SW-1:0] side_in,
    output logic               out_vld,
    output logic [QW-1:0]      quo,
    output logic [SW-1:0]      side_out
);

    localparam int WW = NW + DW + QW;

    logic [NW-1:0] rem_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic          vld_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic [NW-1:0] rem_cur;
        logic [DW-1:0] den_cur;
        logic [QW-1:0] quo_cur;
        logic [SW-1:0] side_cur;
        logic          vld_cur;
        logic [WW-1:0] dsh;
        logic [WW-1:0] rem_w;
        logic          take;
        logic [QW-1:0] quo_next;
        logic [NW-1:0] rem_next;

        if (k == 0) begin : g_first
            assign rem_cur  = num;
            assign den_cur  = den;
            assign quo_cur  = '0;
            assign side_cur = side_in;
            assign vld_cur  = in_vld;
        end else begin : g_rest
            assign rem_cur  = rem_reg[k-1];
            assign den_cur  = den_reg[k-1];
            assign quo_cur  = quo_reg[k-1];
            assign side_cur = side_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
        end

        always_comb
        begin
            dsh      = WW'(den_cur) << B;
            rem_w    = WW'(rem_cur);
            take     = rem_w >= dsh;
            quo_next = quo_cur;
            quo_next[B] = take;
            rem_next = take ? NW'(rem_w - dsh) : rem_cur;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_cur;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_cur;
            end
        end
    end

    assign out_vld  = vld_reg[QW-1];
    assign quo      = quo_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule
`default_nettype wire

[hw/rtl/gtf_mode_timing_generator.sv]
`default_nettype none
// GTF mode timing generator. One request beat carries an active size, a
// refresh rate and an interlace flag; one result beat returns the GTF timing,
// or status 1 with all other fields zero. The block takes one beat per cycle
// while no result waits; its pipeline is built from three pipelined restoring
// dividers (27, 8 and 21 quotient bits, one bit per stage) plus thirteen
// multiply and check stages. The whole pipeline holds while a result waits.
module gtf_mode_timing_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [12:0] active_width,
    input  wire logic [12:0] active_height,
    input  wire logic [10:0] refresh_hz,
    input  wire logic        want_interlaced,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             status,
    output logic [12:0]      h_visible,
    output logic [12:0]      v_visible,
    output logic [15:0]      h_total,
    output logic [15:0]      h_front_porch,
    output logic [15:0]      h_sync_width,
    output logic [15:0]      v_total,
    output logic [25:0]      pixel_clock,
    output logic [21:0]      refresh_milli_hz,
    output logic [1:0]       interlace_mode
);

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // stage A
    logic        a_vld_reg, a_err_reg, a_il_reg;
    logic [12:0] a_h_reg;
    logic [10:0] a_rr_reg;
    logic [9:0]  a_xc_reg;
    logic [24:0] a_hp1r_reg;
    logic [14:0] a_rr11_reg;
    logic [14:0] a_rr11_next;

    assign a_rr11_next = 15'(refresh_hz) * 15'(gtfmtg_pkg::MIN_VSYNCBP);

    // stage B
    logic        b_vld_reg;
    logic [gtfmtg_pkg::DIV1_NW-1:0] b_n1_reg;
    logic [gtfmtg_pkg::DIV1_DW-1:0] b_d1_reg;
    gtfmtg_pkg::s1_t b_s1_reg;

    logic        d1_vld;
    logic [gtfmtg_pkg::DIV1_QW-1:0] d1_q;
    gtfmtg_pkg::s1_t d1_s;

    // stage C
    logic        c_vld_reg;
    gtfmtg_pkg::s1_t c_s1_reg;
    gtfmtg_pkg::s1_t c_s1_next;
    logic [15:0] c_vtot_reg;
    logic [27:0] c_vtot_full;

    // stage D
    logic        d_vld_reg;
    gtfmtg_pkg::s2_t d_s2_reg;

    // stage E
    logic        e_vld_reg;
    gtfmtg_pkg::s2_t e_s2_reg;
    gtfmtg_pkg::s2_t e_s2_next;
    logic [26:0] e_idn_reg;
    logic [gtfmtg_pkg::DIV2_DW-1:0] e_d2_reg;

    // stage F
    logic        f_vld_reg;
    gtfmtg_pkg::s2_t f_s2_reg;
    logic [36:0] f_idnx_reg;
    logic [gtfmtg_pkg::DIV2_DW-1:0] f_d2_reg;
    logic [gtfmtg_pkg::DIV2_NW-1:0] f_n2;

    logic        d2_vld;
    logic [gtfmtg_pkg::DIV2_QW-1:0] d2_q;
    gtfmtg_pkg::s2_t d2_s;

    // stage H
    logic        h_vld_reg;
    gtfmtg_pkg::s2_t h_s2_reg;
    logic [7:0]  h_hb_reg;
    logic [10:0] h_htc_reg;
    logic [7:0]  h_hsc_reg;
    logic [10:0] h_htc_next;
    logic [23:0] h_hs_prod;

    // stage I
    logic        i_vld_reg;
    gtfmtg_pkg::s3_t i_s3_reg;
    logic [10:0] i_htc_reg;
    logic [26:0] i_idd_reg;
    logic [16:0] i_q1_reg;
    logic [13:0] i_hsync;
    logic [13:0] i_hb8;
    logic [54:0] i_q1_prod;

    // stage P
    logic        p_vld_reg;
    gtfmtg_pkg::s3_t p_s3_reg;
    logic [10:0] p_htc_reg;
    logic [10:0] p_ra_reg;
    logic [27:0] p_hq_reg;
    logic [26:0] p_ra_full;

    // stage Q
    logic        q_vld_reg;
    gtfmtg_pkg::s3_t q_s3_reg;
    logic [21:0] q_n2_reg;
    logic [27:0] q_hq_reg;

    // stage J
    logic        j_vld_reg;
    gtfmtg_pkg::s4_t j_s4_reg;
    gtfmtg_pkg::s3_t j_s3_next;
    logic [43:0] j_n2_prod;
    logic [27:0] j_pclk_full;

    // stage K
    logic        k_vld_reg;
    gtfmtg_pkg::s4_t k_s4_reg;
    logic [gtfmtg_pkg::DIV3_NW-1:0] k_n3_reg;
    logic [gtfmtg_pkg::DIV3_DW-1:0] k_d3_reg;

    logic        d3_vld;
    logic [gtfmtg_pkg::DIV3_QW-1:0] d3_q;
    gtfmtg_pkg::s4_t d3_s;

    // output stage
    logic        out_vld_reg;
    logic        status_reg;
    logic [12:0] h_visible_reg, v_visible_reg;
    logic [15:0] h_total_reg, h_front_porch_reg, h_sync_width_reg, v_total_reg;
    logic [25:0] pixel_clock_reg;
    logic [21:0] refresh_milli_hz_reg;
    logic [1:0]  interlace_mode_reg;

    assign c_vtot_full = 28'(d1_q) + 28'(d1_s.h) + 28'(gtfmtg_pkg::MIN_VPORCH);
    assign f_n2        = (39'(f_idnx_reg) << 1) + 39'(f_idnx_reg);
    assign h_htc_next  = 11'(d2_s.xcells) + {2'b00, d2_q, 1'b0};
    assign h_hs_prod   = 24'({h_htc_next, 1'b0}) * 24'(gtfmtg_pkg::HS_RECIP);
    assign i_hsync     = 14'(h_hsc_reg) * 14'(gtfmtg_pkg::CELL_GRAN);
    assign i_hb8       = 14'(h_hb_reg) * 14'(gtfmtg_pkg::CELL_GRAN);
    assign i_q1_prod   = 55'(h_s2_reg.idd) * 55'(gtfmtg_pkg::PCLK_R1);
    assign p_ra_full   = i_idd_reg - 27'(i_q1_reg) * 27'(gtfmtg_pkg::PCLK_DIV);
    assign j_n2_prod   = 44'(q_n2_reg) * 44'(gtfmtg_pkg::PCLK_R2);
    assign j_pclk_full = q_hq_reg + 28'(j_n2_prod[gtfmtg_pkg::PCLK_R2_SHIFT +: 12]);

    always_comb
    begin
        c_s1_next     = d1_s;
        c_s1_next.err = d1_s.err || (c_vtot_full > 28'hFFFF);
        e_s2_next     = d_s2_reg;
        e_s2_next.err = d_s2_reg.err || (d_s2_reg.idd <= 27'(gtfmtg_pkg::DUTY_OFF));
        j_s3_next     = q_s3_reg;
        j_s3_next.err = q_s3_reg.err || (j_pclk_full[27:26] != 2'b00);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
            i_vld_reg   <= 1'b0;
            p_vld_reg   <= 1'b0;
            q_vld_reg   <= 1'b0;
            j_vld_reg   <= 1'b0;
            k_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg   <= in_valid;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= d1_vld;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= d_vld_reg;
            f_vld_reg   <= e_vld_reg;
            h_vld_reg   <= d2_vld;
            i_vld_reg   <= h_vld_reg;
            p_vld_reg   <= i_vld_reg;
            q_vld_reg   <= p_vld_reg;
            j_vld_reg   <= q_vld_reg;
            k_vld_reg   <= j_vld_reg;
            out_vld_reg <= d3_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_err_reg  <= (active_width == '0) || (active_height == '0)
                          || (refresh_hz == '0)
                          || (a_rr11_next >= 15'(gtfmtg_pkg::VSYNCBP_SCALE));
            a_il_reg   <= want_interlaced;
            a_h_reg    <= active_height;
            a_rr_reg   <= refresh_hz;
            a_xc_reg   <= active_width[12:3];
            a_hp1r_reg <= (25'(active_height) + 25'(gtfmtg_pkg::MIN_VPORCH))
                          * 25'(refresh_hz);
            a_rr11_reg <= a_rr11_next;

            b_n1_reg        <= 29'(a_hp1r_reg) * 29'(gtfmtg_pkg::MIN_VSYNCBP);
            b_d1_reg        <= 15'(gtfmtg_pkg::VSYNCBP_SCALE) - a_rr11_reg;
            b_s1_reg.err    <= a_err_reg;
            b_s1_reg.il     <= a_il_reg;
            b_s1_reg.h      <= a_h_reg;
            b_s1_reg.rr     <= a_rr_reg;
            b_s1_reg.xcells <= a_xc_reg;

            c_s1_reg     <= c_s1_next;
            c_vtot_reg   <= c_vtot_full[15:0];

            d_s2_reg.err    <= c_s1_reg.err;
            d_s2_reg.il     <= c_s1_reg.il;
            d_s2_reg.h      <= c_s1_reg.h;
            d_s2_reg.xcells <= c_s1_reg.xcells;
            d_s2_reg.vtot   <= c_vtot_reg;
            d_s2_reg.idd    <= 27'(c_vtot_reg) * 27'(c_s1_reg.rr);

            e_s2_reg     <= e_s2_next;
            e_idn_reg    <= d_s2_reg.idd - 27'(gtfmtg_pkg::DUTY_OFF);
            e_d2_reg     <= 31'(d_s2_reg.idd) * 31'(gtfmtg_pkg::HB_DEN_MUL)
                            + 31'(gtfmtg_pkg::HB_DEN_ADD);

            f_s2_reg   <= e_s2_reg;
            f_idnx_reg <= 37'(e_idn_reg) * 37'(e_s2_reg.xcells);
            f_d2_reg   <= e_d2_reg;

            h_s2_reg  <= d2_s;
            h_hb_reg  <= d2_q;
            h_htc_reg <= h_htc_next;
            h_hsc_reg <= h_hs_prod[gtfmtg_pkg::HS_SHIFT +: 8];

            i_s3_reg.err    <= h_s2_reg.err || (i_hsync == '0) || (i_hsync > i_hb8);
            i_s3_reg.il     <= h_s2_reg.il;
            i_s3_reg.h      <= h_s2_reg.h;
            i_s3_reg.xcells <= h_s2_reg.xcells;
            i_s3_reg.vtot   <= h_s2_reg.vtot;
            i_s3_reg.htot   <= 14'(h_htc_reg) * 14'(gtfmtg_pkg::CELL_GRAN);
            i_s3_reg.hsync  <= i_hsync;
            i_s3_reg.hfp    <= i_hb8 - i_hsync;
            i_htc_reg       <= h_htc_reg;
            i_idd_reg       <= h_s2_reg.idd;
            i_q1_reg        <= i_q1_prod[gtfmtg_pkg::PCLK_R1_SHIFT +: 17];

            p_s3_reg  <= i_s3_reg;
            p_htc_reg <= i_htc_reg;
            p_ra_reg  <= p_ra_full[10:0];
            p_hq_reg  <= 28'(i_htc_reg) * 28'(i_q1_reg);

            q_s3_reg <= p_s3_reg;
            q_n2_reg <= 22'(p_htc_reg) * 22'(p_ra_reg);
            q_hq_reg <= p_hq_reg;

            j_s4_reg.s3   <= j_s3_next;
            j_s4_reg.pclk <= j_pclk_full[25:0];

            k_s4_reg <= j_s4_reg;
            k_n3_reg <= 50'(j_s4_reg.pclk) * 50'(gtfmtg_pkg::RRX_SCALE);
            k_d3_reg <= 30'(j_s4_reg.s3.htot) * 30'(j_s4_reg.s3.vtot);

            status_reg <= d3_s.s3.err;
            if (d3_s.s3.err)
            begin
                h_visible_reg        <= '0;
                v_visible_reg        <= '0;
                h_total_reg          <= '0;
                h_front_porch_reg    <= '0;
                h_sync_width_reg     <= '0;
                v_total_reg          <= '0;
                pixel_clock_reg      <= '0;
                refresh_milli_hz_reg <= '0;
                interlace_mode_reg   <= gtfmtg_pkg::MODE_PROGRESSIVE;
            end
            else
            begin
                h_visible_reg        <= {d3_s.s3.xcells, 3'b000};
                h_total_reg          <= 16'(d3_s.s3.htot);
                h_front_porch_reg    <= 16'(d3_s.s3.hfp);
                h_sync_width_reg     <= 16'(d3_s.s3.hsync);
                refresh_milli_hz_reg <= 22'(d3_q);
                if (d3_s.s3.il)
                begin
                    v_visible_reg      <= 13'((14'(d3_s.s3.h) + 14'd1) >> 1);
                    v_total_reg        <= d3_s.s3.vtot >> 1;
                    pixel_clock_reg    <= d3_s.pclk >> 1;
                    interlace_mode_reg <= d3_s.s3.vtot[0] ? gtfmtg_pkg::MODE_FIELD2_VBL
                                                          : gtfmtg_pkg::MODE_NONE;
                end
                else
                begin
                    v_visible_reg      <= d3_s.s3.h;
                    v_total_reg        <= d3_s.s3.vtot;
                    pixel_clock_reg    <= d3_s.pclk;
                    interlace_mode_reg <= gtfmtg_pkg::MODE_PROGRESSIVE;
                end
            end
        end
    end

    gtfmtg_div #(
        .NW(gtfmtg_pkg::DIV1_NW), .DW(gtfmtg_pkg::DIV1_DW),
        .QW(gtfmtg_pkg::DIV1_QW), .SW($bits(gtfmtg_pkg::s1_t))
    ) u_div_vsbp (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(b_vld_reg), .num(b_n1_reg), .den(b_d1_reg), .side_in(b_s1_reg),
        .out_vld(d1_vld), .quo(d1_q), .side_out(d1_s)
    );

    gtfmtg_div #(
        .NW(gtfmtg_pkg::DIV2_NW), .DW(gtfmtg_pkg::DIV2_DW),
        .QW(gtfmtg_pkg::DIV2_QW), .SW($bits(gtfmtg_pkg::s2_t))
    ) u_div_hblank (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(f_vld_reg), .num(f_n2), .den(f_d2_reg), .side_in(f_s2_reg),
        .out_vld(d2_vld), .quo(d2_q), .side_out(d2_s)
    );

    gtfmtg_div #(
        .NW(gtfmtg_pkg::DIV3_NW), .DW(gtfmtg_pkg::DIV3_DW),
        .QW(gtfmtg_pkg::DIV3_QW), .SW($bits(gtfmtg_pkg::s4_t))
    ) u_div_refresh (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(k_vld_reg), .num(k_n3_reg), .den(k_d3_reg), .side_in(k_s4_reg),
        .out_vld(d3_vld), .quo(d3_q), .side_out(d3_s)
    );

    assign out_valid        = out_vld_reg;
    assign status           = status_reg;
    assign h_visible        = h_visible_reg;
    assign v_visible        = v_visible_reg;
    assign h_total          = h_total_reg;
    assign h_front_porch    = h_front_porch_reg;
    assign h_sync_width     = h_sync_width_reg;
    assign v_total          = v_total_reg;
    assign pixel_clock      = pixel_clock_reg;
    assign refresh_milli_hz = refresh_milli_hz_reg;
    assign interlace_mode   = interlace_mode_reg;

endmodule
`default_nettype wire

[verif/tb_top.sv]
`default_nettype none

typedef struct {
    logic        status;
    logic [12:0] h_visible;
    logic [12:0] v_visible;
    logic [15:0] h_total;
    logic [15:0] h_front_porch;
    logic [15:0] h_sync_width;
    logic [15:0] v_total;
    logic [25:0] pixel_clock;
    logic [21:0] refresh_milli_hz;
    logic [1:0]  interlace_mode;
} gtf_timing_t;

class gtf_scoreboard;
    gtf_timing_t pending_timings[$];
    int          fail_count;

    function new();
        fail_count = 0;
    endfunction

    function gtf_timing_t gtf_timing(logic [12:0] w, logic [12:0] h, logic [10:0] rr,
                                     logic il);
        gtf_timing_t t;
        longint unsigned xcells, vsbp, vtot, idd, idn, hb_cells, hblank;
        longint unsigned htcells, htot, hsync, hfp, pclk, rrx1k, vvis, vout, mode;
        t = '{default: '0};
        t.status = 1'b1;
        if (w == 0 || h == 0 || rr == 0) return t;
        xcells = w / gtfmtg_pkg::CELL_GRAN;
        if (rr * gtfmtg_pkg::MIN_VSYNCBP >= gtfmtg_pkg::VSYNCBP_SCALE) return t;
        vsbp = ((h + gtfmtg_pkg::MIN_VPORCH) * gtfmtg_pkg::MIN_VSYNCBP * rr) /
               (gtfmtg_pkg::VSYNCBP_SCALE - gtfmtg_pkg::MIN_VSYNCBP * rr);
        vtot = vsbp + h + gtfmtg_pkg::MIN_VPORCH;
        if (vtot > 65535) return t;
        idd = vtot * rr;
        if (idd <= gtfmtg_pkg::DUTY_OFF) return t;
        idn = idd - gtfmtg_pkg::DUTY_OFF;
        hb_cells = (idn * 3 * xcells) / (2 * (300 * idd / gtfmtg_pkg::C_PRIME - idn * 3));
        hblank = hb_cells * 2 * gtfmtg_pkg::CELL_GRAN;
        htcells = xcells + hblank / gtfmtg_pkg::CELL_GRAN;
        htot = htcells * gtfmtg_pkg::CELL_GRAN;
        hsync = (htcells * gtfmtg_pkg::HSYNC_PCT / 100) * gtfmtg_pkg::CELL_GRAN;
        if (hsync == 0 || hsync * 2 > hblank) return t;
        if (htot > 65535) return t;
        hfp = hblank / 2 - hsync;
        pclk = (htcells * vtot * rr) / gtfmtg_pkg::PCLK_DIV;
        if (pclk > 64'h3FFFFFF) return t;
        rrx1k = (pclk * gtfmtg_pkg::PCLK_SCALE * 1000) / (htot * vtot);
        vvis = h;
        vout = vtot;
        mode = gtfmtg_pkg::MODE_PROGRESSIVE;
        if (il)
        begin
            mode = vtot[0] ? gtfmtg_pkg::MODE_FIELD2_VBL : gtfmtg_pkg::MODE_NONE;
            pclk = pclk >> 1;
            vout = vout >> 1;
            vvis = (vvis + 1) / 2;
        end
        t.status = 1'b0;
        t.h_visible = 13'(xcells * gtfmtg_pkg::CELL_GRAN);
        t.v_visible = 13'(vvis);
        t.h_total = 16'(htot);
        t.h_front_porch = 16'(hfp);
        t.h_sync_width = 16'(hsync);
        t.v_total = 16'(vout);
        t.pixel_clock = 26'(pclk);
        t.refresh_milli_hz = 22'(rrx1k);
        t.interlace_mode = 2'(mode);
        return t;
    endfunction

    function void note_request(logic [12:0] w, logic [12:0] h, logic [10:0] rr, logic il);
        pending_timings.push_back(gtf_timing(w, h, rr, il));
    endfunction

    function void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    function void check_timing(gtf_timing_t a);
        gtf_timing_t e;
        if (pending_timings.size() == 0)
        begin
            $error("unexpected result beat");
            fail_count++;
            return;
        end
        e = pending_timings.pop_front();
        check_field("status", e.status, a.status);
        check_field("h_visible", e.h_visible, a.h_visible);
        check_field("v_visible", e.v_visible, a.v_visible);
        check_field("h_total", e.h_total, a.h_total);
        check_field("h_front_porch", e.h_front_porch, a.h_front_porch);
        check_field("h_sync_width", e.h_sync_width, a.h_sync_width);
        check_field("v_total", e.v_total, a.v_total);
        check_field("pixel_clock", e.pixel_clock, a.pixel_clock);
        check_field("refresh_milli_hz", e.refresh_milli_hz, a.refresh_milli_hz);
        check_field("interlace_mode", e.interlace_mode, a.interlace_mode);
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [12:0] active_width = '0;
    logic [12:0] active_height = '0;
    logic [10:0] refresh_hz = '0;
    logic        want_interlaced = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        status;
    logic [12:0] h_visible;
    logic [12:0] v_visible;
    logic [15:0] h_total;
    logic [15:0] h_front_porch;
    logic [15:0] h_sync_width;
    logic [15:0] v_total;
    logic [25:0] pixel_clock;
    logic [21:0] refresh_milli_hz;
    logic [1:0]  interlace_mode;

    gtf_scoreboard timing_board = new();
    longint cycle_count = 0;
    bit     calm_phase = 1'b0;
    bit     hold_off = 1'b0;

    gtf_mode_timing_generator i_dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("gtf_mode_timing_generator verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        gtf_timing_t r;
        if (rst_n && out_valid && out_ready)
        begin
            r.status = status;
            r.h_visible = h_visible;
            r.v_visible = v_visible;
            r.h_total = h_total;
            r.h_front_porch = h_front_porch;
            r.h_sync_width = h_sync_width;
            r.v_total = v_total;
            r.pixel_clock = pixel_clock;
            r.refresh_milli_hz = refresh_milli_hz;
            r.interlace_mode = interlace_mode;
            timing_board.check_timing(r);
        end
        if (rst_n && in_valid && in_ready)
            timing_board.note_request(active_width, active_height, refresh_hz,
                                      want_interlaced);
    end

    always @(negedge clk)
        out_ready <= !hold_off && (calm_phase || $urandom_range(99) >= 11);

    task automatic send_request(logic [12:0] w, logic [12:0] h, logic [10:0] rr, logic il);
        while (!calm_phase && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        active_width <= w;
        active_height <= h;
        refresh_hz <= rr;
        want_interlaced <= il;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [12:0] w, h;
        logic [10:0] rr;
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            w = 13'($urandom_range(2048, 8));
            h = 13'($urandom_range(1600, 1));
            rr = 11'($urandom_range(200, 20));
        end
        else if (pick < 90)
        begin
            w = 13'($urandom_range(8191, 1));
            h = 13'($urandom_range(8191, 1));
            rr = 11'($urandom_range(1818, 1));
        end
        else
        begin
            w = 13'($urandom);
            h = 13'($urandom);
            rr = 11'($urandom);
        end
        send_request(w, h, rr, 1'($urandom_range(1)));
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_request(13'd640, 13'd480, 11'd60, 1'b0);
        send_request(13'd1920, 13'd1080, 11'd60, 1'b1);
        send_request(13'd1920, 13'd1081, 11'd60, 1'b1);
        send_request(13'd0, 13'd480, 11'd60, 1'b0);
        send_request(13'd640, 13'd0, 11'd60, 1'b0);
        send_request(13'd640, 13'd480, 11'd0, 1'b0);
        send_request(13'd640, 13'd480, 11'd1818, 1'b0);
        send_request(13'd640, 13'd480, 11'd1819, 1'b0);
        send_request(13'd640, 13'd480, 11'd2047, 1'b1);
        send_request(13'd8191, 13'd8191, 11'd1817, 1'b0);
        send_request(13'd8191, 13'd8191, 11'd1, 1'b1);
        send_request(13'd8191, 13'd8191, 11'd60, 1'b0);
        send_request(13'd7, 13'd480, 11'd60, 1'b0);
        send_request(13'd8, 13'd1, 11'd1, 1'b0);
        send_request(13'd1024, 13'd1, 11'd1, 1'b1);
        send_request(13'd16, 13'd8, 11'd100, 1'b0);
        send_request(13'd1024, 13'd768, 11'd85, 1'b1);
        send_request(13'd8191, 13'd4000, 11'd100, 1'b1);
        send_request(13'd5461, 13'd2730, 11'd1365, 1'b1);
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            repeat (150) send_random();
        join
        for (int i = 0; i < 1280; i++)
        begin
            calm_phase = (i >= 500 && i < 700);
            send_random();
        end
        calm_phase = 1'b0;
        in_valid <= 1'b0;
        while (timing_board.pending_timings.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
        if (timing_board.fail_count == 0 && timing_board.pending_timings.size() == 0)
            $display("gtf_mode_timing_generator verification clean");
        else
            $display("gtf_mode_timing_generator verification failed");
        $finish;
    end
endmodule

`default_nettype wire
